@@ rtl/core/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] POS_EMPTY = 2'd0;
   localparam logic [1:0] POS_TWO   = 2'd2;
   localparam logic [1:0] POS_THREE = 2'd3;

   localparam logic [1:0] CNT_NONE  = 2'd0;
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_TWO   = 2'd2;
   localparam logic [1:0] CNT_THREE = 2'd3;

   typedef struct packed {
      logic [7:0] data0;
      logic [7:0] data1;
      logic [7:0] data2;
      logic [1:0] count;
      logic       text_done;
   } b64d_job_type;

   typedef struct packed {
      logic [1:0] group_pos;
      logic       stopped;
   } b64d_front_status_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } b64d_sextet_type;

   function automatic b64d_sextet_type sextet_of(input logic [7:0] ch);
      b64d_sextet_type res;
      res.hit   = 1'b1;
      res.value = 6'd0;
      case (ch) inside
         ["A":"Z"]: res.value = 6'(ch - 8'h41);
         ["a":"z"]: res.value = 6'(ch - 8'h61 + 8'd26);
         ["0":"9"]: res.value = 6'(ch - 8'h30 + 8'd52);
         8'h2B:     res.value = 6'd62;
         8'h2F:     res.value = 6'd63;
         default:   res.hit   = 1'b0;
      endcase
      return res;
   endfunction

endpackage

@@ rtl/core/b64d_req_if.sv @@
// ----------------------------------------------------------------------------
// b64d_req_if
// Character channel: one encoded character and its end flag per transaction.
// ----------------------------------------------------------------------------
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       end_of_text;

   modport source (output valid, output symbol, output end_of_text, input ready);
   modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

@@ rtl/core/b64d_rsp_if.sv @@
// ----------------------------------------------------------------------------
// b64d_rsp_if
// Byte channel: one decoded byte and its run flags per transaction.
// ----------------------------------------------------------------------------
interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_of_run;
   logic       text_done;

   modport source (output valid, output data_byte, output last_of_run,
                   output text_done, input ready);
   modport sink   (input valid, input data_byte, input last_of_run,
                   input text_done, output ready);
endinterface

@@ rtl/core/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_queue
// Small job queue between the character front end and the byte back end.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  b64d_job_type push_job,
   input  logic         pop,
   output b64d_job_type pop_job,
   output logic         full,
   output logic         empty
);

   b64d_job_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/core/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, decodes sextets, gathers groups and builds byte jobs.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   b64d_req_if.sink              req_ch,
   input  logic                  q_full,
   output logic                  q_push,
   output b64d_job_type          q_job,
   output b64d_front_status_type status
);

   logic [1:0]      pos_ff, pos_in;
   logic [17:0]     acc_ff, acc_in;
   logic            stopped_ff, stopped_in;
   logic            fire;
   b64d_sextet_type sx;
   logic [23:0]     word;
   b64d_job_type    job;

   assign req_ch.ready = ~q_full;
   assign fire         = req_ch.valid & ~q_full;
   assign sx           = sextet_of(req_ch.symbol);
   assign word         = {acc_ff, sx.value};

   always_comb begin
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      stopped_in    = stopped_ff;
      job.data0     = word[23:16];
      job.data1     = word[15:8];
      job.data2     = word[7:0];
      job.count     = CNT_NONE;
      job.text_done = req_ch.end_of_text;

      // absorb the character
      if (!stopped_ff) begin
         if (!sx.hit) begin
            stopped_in = 1'b1;
         end else if (pos_ff == POS_THREE) begin
            job.count = CNT_THREE;
            pos_in    = POS_EMPTY;
            acc_in    = '0;
         end else begin
            acc_in = {acc_ff[11:0], sx.value};
            pos_in = pos_ff + 1'b1;
         end
      end

      // flush the partial group, then restart
      if (req_ch.end_of_text) begin
         if (pos_in == POS_TWO) begin
            job.data0 = {acc_in[11:6], acc_in[5:4]};
            job.count = CNT_ONE;
         end else if (pos_in == POS_THREE) begin
            job.data0 = {acc_in[17:12], acc_in[11:10]};
            job.data1 = {acc_in[9:6], acc_in[5:2]};
            job.count = CNT_TWO;
         end
         pos_in     = POS_EMPTY;
         acc_in     = '0;
         stopped_in = 1'b0;
      end
   end

   assign q_job            = job;
   assign q_push           = fire & (job.count != CNT_NONE);
   assign status.group_pos = pos_ff;
   assign status.stopped   = stopped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_EMPTY;
         acc_ff     <= '0;
         stopped_ff <= 1'b0;
      end else if (fire) begin
         pos_ff     <= pos_in;
         acc_ff     <= acc_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

@@ rtl/core/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Takes byte jobs from the queue and emits one byte per transaction.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  b64d_job_type q_job,
   input  logic         q_empty,
   output logic         q_pop,
   b64d_rsp_if.source   rsp_ch
);

   b64d_job_type cur_ff, cur_in;
   logic         cur_valid_ff, cur_valid_in;
   logic [1:0]   idx_ff, idx_in;
   logic         fire, at_last, load;

   assign fire    = cur_valid_ff & rsp_ch.ready;
   assign at_last = ((idx_ff + 2'd1) == cur_ff.count);
   assign load    = ~cur_valid_ff | (fire & at_last);
   assign q_pop   = load & ~q_empty;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_in       = q_job;
         cur_valid_in = ~q_empty;
         idx_in       = 2'd0;
      end else if (fire) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_ch.data_byte = cur_ff.data0;
         2'd1:    rsp_ch.data_byte = cur_ff.data1;
         default: rsp_ch.data_byte = cur_ff.data2;
      endcase
   end

   assign rsp_ch.valid       = cur_valid_ff;
   assign rsp_ch.last_of_run = at_last;
   assign rsp_ch.text_done   = at_last & cur_ff.text_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

@@ rtl/core/base64_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming base64 decoder: characters in, decoded bytes out.
// ----------------------------------------------------------------------------
// The decoder accepts one character per cycle whenever its four-entry job
// queue has room, and emits one byte per cycle while the response side is
// ready and jobs wait. A full group of four characters yields three bytes,
// so the byte port sets the sustained rate: a character that completes a
// group makes three bytes, a flushed tail one or two, all others none.
// Characters are still taken while the response side stalls, until the
// queue fills. Bytes pass through the job queue, then the back end's job
// register. A '=', NUL or other non-alphabet character stops decoding
// until the end flag; the end flag flushes any partial group and restarts.
module base64_stream_decoder_unit import b64d_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   b64d_req_if.sink   req_ch,
   b64d_rsp_if.source rsp_ch
);

   logic                  q_push, q_pop, q_full, q_empty;
   b64d_job_type          push_job, pop_job;
   b64d_front_status_type front_status;

   b64d_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (push_job),
      .status (front_status)
   );

   b64d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   b64d_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_job   (pop_job),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   // never push into a full queue
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("job pushed into full queue");

   // never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("job popped from empty queue");

   // end flag restarts the front end
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.end_of_text) |=>
      (front_status.group_pos == POS_EMPTY && !front_status.stopped))
      else $error("front state not cleared after end of text");

   // queued jobs always carry at least one byte
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (push_job.count != CNT_NONE))
      else $error("empty job pushed");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming base64 decoder. Encoded characters are
// pushed with random gaps and end flags; a scoreboard tracks the group state,
// predicts every decoded byte with its run flags and checks each byte
// transaction in order. The byte side stalls at random and twice holds off
// long enough to back the decoder up into the character side.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [7:0] data_byte;
   logic       last_of_run;
   logic       text_done;
} decoded_byte_type;

typedef struct packed {
   logic [7:0] symbol;
   logic       end_of_text;
} char_item_type;

class byte_scoreboard;
   logic [1:0]       group_pos;
   logic [17:0]      sextets;
   bit               halted;
   decoded_byte_type expected_bytes[$];
   int               errors;

   function new();
      restart();
      errors = 0;
   endfunction

   function void restart();
      group_pos = b64d_pkg::POS_EMPTY;
      sextets   = '0;
      halted    = 1'b0;
   endfunction

   function int sextet_value(logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return int'(ch) - int'("A");
      if (ch >= "a" && ch <= "z") return int'(ch) - int'("a") + 26;
      if (ch >= "0" && ch <= "9") return int'(ch) - int'("0") + 52;
      if (ch == "+") return 62;
      if (ch == "/") return 63;
      return -1;
   endfunction

   function decoded_byte_type plain_byte(logic [7:0] d);
      decoded_byte_type b;
      b.data_byte   = d;
      b.last_of_run = 1'b0;
      b.text_done   = 1'b0;
      return b;
   endfunction

   function int pending();
      return expected_bytes.size();
   endfunction

   function void note_char(logic [7:0] ch, logic eot);
      decoded_byte_type made[$];
      int               v;
      logic [23:0]      word;
      if (!halted) begin
         v = sextet_value(ch);
         if (v < 0) begin
            halted = 1'b1;
         end else if (group_pos == b64d_pkg::POS_THREE) begin
            word = {sextets, 6'(v)};
            made.push_back(plain_byte(word[23:16]));
            made.push_back(plain_byte(word[15:8]));
            made.push_back(plain_byte(word[7:0]));
            group_pos = b64d_pkg::POS_EMPTY;
            sextets   = '0;
         end else begin
            sextets   = {sextets[11:0], 6'(v)};
            group_pos = group_pos + 2'd1;
         end
      end
      if (eot) begin
         if (group_pos == b64d_pkg::POS_TWO) begin
            made.push_back(plain_byte({sextets[11:6], sextets[5:4]}));
         end else if (group_pos == b64d_pkg::POS_THREE) begin
            made.push_back(plain_byte({sextets[17:12], sextets[11:10]}));
            made.push_back(plain_byte({sextets[9:6], sextets[5:2]}));
         end
         restart();
      end
      if (made.size() > 0) begin
         made[made.size() - 1].last_of_run = 1'b1;
         made[made.size() - 1].text_done   = eot;
      end
      foreach (made[i]) expected_bytes.push_back(made[i]);
   endfunction

   task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
   endtask

   task check_byte(logic [7:0] d, logic last, logic done);
      decoded_byte_type want;
      if (expected_bytes.size() == 0) begin
         report($sformatf("unexpected byte %02h last=%0b done=%0b", d, last, done));
      end else begin
         want = expected_bytes.pop_front();
         if (d !== want.data_byte)
            report($sformatf("data_byte %02h, want %02h", d, want.data_byte));
         if (last !== want.last_of_run)
            report($sformatf("last_of_run %0b, want %0b (byte %02h)",
                             last, want.last_of_run, want.data_byte));
         if (done !== want.text_done)
            report($sformatf("text_done %0b, want %0b (byte %02h)",
                             done, want.text_done, want.data_byte));
      end
   endtask
endclass

module tb_top;
   import b64d_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   b64d_req_if req_ch ();
   b64d_rsp_if rsp_ch ();

   base64_stream_decoder_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   byte_scoreboard sb = new();
   char_item_type  char_plan[$];
   int             idle_cycles = 0;
   int             no_gap_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_char(logic [7:0] sym, logic eot);
      char_item_type c;
      c.symbol      = sym;
      c.end_of_text = eot;
      char_plan.push_back(c);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
   endfunction

   function automatic logic [7:0] alphabet_char(int v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      return (v == 62) ? 8'("+") : 8'("/");
   endfunction

   task automatic send_item(logic [7:0] sym, logic eot);
      int gap;
      if (no_gap_left > 0) begin
         gap = 0;
         no_gap_left--;
      end else if ($urandom_range(0, 15) == 0) begin
         gap = 0;
         no_gap_left = 20;
      end else begin
         gap = $urandom_range(0, 3);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.symbol      <= sym;
      req_ch.end_of_text <= eot;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   // byte side: random stalls, calm bursts, two long hold-offs
   initial begin
      int gap;
      int taken;
      int calm;
      taken = 0;
      calm  = 0;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == 40 || taken == 160) begin
            gap = 80;
         end else if (calm > 0) begin
            gap = 0;
            calm--;
         end else if ($urandom_range(0, 15) == 0) begin
            gap  = 0;
            calm = 25;
         end else begin
            gap = $urandom_range(0, 3);
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         taken++;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_char(req_ch.symbol, req_ch.end_of_text);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_byte(rsp_ch.data_byte, rsp_ch.last_of_run, rsp_ch.text_done);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      logic [7:0] text[$];
      int         style;
      int         len;
      req_ch.valid       <= 1'b0;
      req_ch.symbol      <= 8'h00;
      req_ch.end_of_text <= 1'b0;

      add_text("TWFu");
      add_text("TWE");
      add_text("TQ=");
      add_char("/", 1'b0);
      add_char("+", 1'b0);
      add_char("A", 1'b0);
      add_char("z", 1'b0);
      add_char(8'h00, 1'b1);
      add_char("Z", 1'b0);
      add_char("a", 1'b0);
      add_char("0", 1'b0);
      add_char(8'hFF, 1'b0);
      add_char("Q", 1'b1);
      add_text("T");
      add_char(8'h80, 1'b1);

      while (char_plan.size() < 372) begin
         style = $urandom_range(0, 9);
         if (style == 0) begin
            add_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else begin
            text.delete();
            len = $urandom_range(1, 12);
            repeat (len) text.push_back(alphabet_char($urandom_range(0, 63)));
            if (style == 1) text[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) begin
               if (len % 4 == 2) begin
                  text.push_back("=");
                  text.push_back("=");
               end else if (len % 4 == 3) begin
                  text.push_back("=");
               end
            end
            if (style == 2) repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
            foreach (text[k]) add_char(text[k], k == text.size() - 1);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (char_plan[i]) send_item(char_plan[i].symbol, char_plan[i].end_of_text);
      req_ch.valid <= 1'b0;
      @(posedge clock);

      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
